[rtl/p1tsa_pkg.sv]
`default_nettype none
package p1tsa_pkg;

	localparam int IDX_W   = 16;   // node index field width
	localparam int CRD_W   = 32;   // coordinate field width
	localparam int DIFF_W  = 33;   // coordinate difference
	localparam int PROD_W  = 66;   // product of two differences
	localparam int SUM_W   = 67;   // sum of two products
	localparam int D2_W    = 68;   // twice |D|
	localparam int QUOT_W  = 32;   // quotient bits kept before saturation
	localparam int NUM_W   = 101;  // dividend / partial remainder width

	localparam logic [CRD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [CRD_W-1:0] NEG_LIMIT = 32'h8000_0000;

	// sideband carried alongside each entry through the divider
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             neg;
		logic             degen;
		logic             last;
	} tag_t;

endpackage
`default_nettype wire

[rtl/p1tsa_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per stage, plus an overflow check stage.
module p1tsa_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          ce,
	input  wire logic                          in_valid,
	input  wire logic [p1tsa_pkg::NUM_W-1:0]   num,
	input  wire logic [p1tsa_pkg::D2_W-1:0]    den2,
	input  wire p1tsa_pkg::tag_t               in_tag,
	output logic                               out_valid,
	output logic [p1tsa_pkg::QUOT_W-1:0]       quot,
	output logic                               ovf,
	output p1tsa_pkg::tag_t                    out_tag
);
	localparam int NW = p1tsa_pkg::NUM_W;
	localparam int DW = p1tsa_pkg::D2_W;
	localparam int QW = p1tsa_pkg::QUOT_W;

	logic                v_s   [0:QW];
	logic [NW-1:0]       rem_s [0:QW];
	logic [QW-1:0]       q_s   [0:QW];
	logic [DW-1:0]       d2_s  [0:QW];
	logic                ovf_s [0:QW];
	p1tsa_pkg::tag_t     tag_s [0:QW];

	// quotient would need more than QW bits
	logic ovf_c;
	assign ovf_c = (num >= (NW'(den2) << QW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ce) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= num;
			q_s[0]   <= '0;
			d2_s[0]  <= den2;
			ovf_s[0] <= ovf_c;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [NW-1:0] sh_c;
		logic          ge_c;
		assign sh_c = NW'(d2_s[k-1]) << (QW - k);
		assign ge_c = (rem_s[k-1] >= sh_c);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ce) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k]      <= ge_c ? (rem_s[k-1] - sh_c) : rem_s[k-1];
				// bit QW-k is still clear in the incoming quotient
				q_s[k]        <= q_s[k-1] | (QW'(ge_c) << (QW - k));
				d2_s[k]       <= d2_s[k-1];
				ovf_s[k]      <= ovf_s[k-1];
				tag_s[k]      <= tag_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quot      = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign out_tag   = tag_s[QW];

endmodule
`default_nettype wire

[rtl/p1_triangle_stiffness_assembly_top.sv]
`default_nettype none
// P1 triangle stiffness element, Laplacian, Q16.16.
// Input channel (tri_valid / tri_stall): one word is one triangle, three node
// indices and three vertex coordinate pairs. Output channel (ent_valid /
// ent_stall): one word is one triplet (row_node, col_node, entry_value) with
// degenerate and last flags; nine words per triangle in column-major order,
// last set on the ninth.
// Throughput: one triplet per cycle while the output is not stalled; a holding
// register issues the nine entries of a triangle one per cycle into the
// pipeline, and the next triangle is taken on the cycle its ninth issues.
// Path: the first triplet of an accepted triangle passes through the holding
// register, multiply, sum, abs, dividend, overflow check, 32 divider stages
// and the output register.
// Reset: asynchronous, active low; clears all valid bits, the pipeline comes
// up empty and takes a triangle at once.
// Stall on a valid output freezes the whole pipeline; nothing is lost or
// repeated. A triangle can be taken while the holding register is empty.
// Zero-area triangles yield nine triplets with value 0 and degenerate set.
module p1_triangle_stiffness_assembly_top #(
	parameter int NODE_INDEX_BITS = 16,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              tri_valid,
	output logic                                   tri_stall,
	input  wire logic [p1tsa_pkg::IDX_W-1:0]       node_a_index,
	input  wire logic [p1tsa_pkg::IDX_W-1:0]       node_b_index,
	input  wire logic [p1tsa_pkg::IDX_W-1:0]       node_c_index,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] ax,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] ay,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] bx,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] by_coord,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] cx,
	input  wire logic signed [p1tsa_pkg::CRD_W-1:0] cy,
	output logic                                   ent_valid,
	input  wire logic                              ent_stall,
	output logic [p1tsa_pkg::IDX_W-1:0]            row_node,
	output logic [p1tsa_pkg::IDX_W-1:0]            col_node,
	output logic signed [p1tsa_pkg::CRD_W-1:0]     entry_value,
	output logic                                   degenerate,
	output logic                                   last
);
	localparam int IW = p1tsa_pkg::IDX_W;
	localparam int CW = p1tsa_pkg::CRD_W;
	localparam int XW = p1tsa_pkg::DIFF_W;
	localparam int PW = p1tsa_pkg::PROD_W;
	localparam int SW = p1tsa_pkg::SUM_W;
	localparam int DW = p1tsa_pkg::D2_W;
	localparam int NW = p1tsa_pkg::NUM_W;
	localparam int QW = p1tsa_pkg::QUOT_W;
	localparam logic [IW-1:0] IDX_MASK = (NODE_INDEX_BITS >= IW) ? {IW{1'b1}} :
		IW'((64'd1 << NODE_INDEX_BITS) - 64'd1);

	// global advance: output register empty or being taken
	logic ce;
	logic ent_valid_q;
	assign ce = !ent_valid_q || !ent_stall;

	// ---------------- holding register and entry sequencer ----------------
	logic                 hold_v_q;
	logic [1:0]           r_q, c_q;
	logic [IW-1:0]        ia_q, ib_q, ic_q;
	logic signed [XW-1:0] nxa_q, nya_q, nxb_q, nyb_q, nxc_q, nyc_q;
	logic signed [XW-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
	logic                 lastk, issue, tri_acc;

	assign lastk     = (r_q == 2'd2) && (c_q == 2'd2);
	assign issue     = hold_v_q && ce;
	assign tri_stall = hold_v_q && !(issue && lastk);
	assign tri_acc   = tri_valid && !tri_stall;

	function automatic logic signed [XW-1:0] sdiff(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] q);
		sdiff = XW'(p) - XW'(q);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			r_q      <= 2'd0;
			c_q      <= 2'd0;
		end else begin
			hold_v_q <= tri_acc || (hold_v_q && !(issue && lastk));
			if (issue) begin
				if (r_q == 2'd2) begin
					r_q <= 2'd0;
					c_q <= lastk ? 2'd0 : c_q + 2'd1;
				end else begin
					r_q <= r_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tri_acc) begin
			ia_q  <= node_a_index & IDX_MASK;
			ib_q  <= node_b_index & IDX_MASK;
			ic_q  <= node_c_index & IDX_MASK;
			// edge normals of the barycentric gradients
			nxa_q <= sdiff(by_coord, cy);
			nya_q <= sdiff(cx, bx);
			nxb_q <= sdiff(cy, ay);
			nyb_q <= sdiff(ax, cx);
			nxc_q <= sdiff(ay, by_coord);
			nyc_q <= sdiff(bx, ax);
			e1x_q <= sdiff(bx, ax);
			e1y_q <= sdiff(by_coord, ay);
			e2x_q <= sdiff(cx, ax);
			e2y_q <= sdiff(cy, ay);
		end
	end

	// row / column selection
	logic signed [XW-1:0] rnx, rny, cnx, cny;
	logic [IW-1:0]        ridx, cidx;
	always_comb begin
		case (r_q)
			2'd0:    begin rnx = nxa_q; rny = nya_q; ridx = ia_q; end
			2'd1:    begin rnx = nxb_q; rny = nyb_q; ridx = ib_q; end
			default: begin rnx = nxc_q; rny = nyc_q; ridx = ic_q; end
		endcase
		case (c_q)
			2'd0:    begin cnx = nxa_q; cny = nya_q; cidx = ia_q; end
			2'd1:    begin cnx = nxb_q; cny = nyb_q; cidx = ib_q; end
			default: begin cnx = nxc_q; cny = nyc_q; cidx = ic_q; end
		endcase
	end

	// ---------------- s1: products ----------------
	logic                 v_s1, last_s1;
	logic [IW-1:0]        row_s1, col_s1;
	logic signed [PW-1:0] pxx_s1, pyy_s1, pd1_s1, pd2_s1;

	// ---------------- s2: sums ----------------
	logic                 v_s2, last_s2;
	logic [IW-1:0]        row_s2, col_s2;
	logic [SW-1:0]        dot_s2, dd_s2;

	// ---------------- s3: magnitudes ----------------
	logic                 v_s3, last_s3, neg_s3, degen_s3;
	logic [IW-1:0]        row_s3, col_s3;
	logic [SW-1:0]        mag_s3, den_s3;

	// ---------------- s4: dividend and divisor ----------------
	logic                 v_s4;
	logic [NW-1:0]        num_s4;
	logic [DW-1:0]        d2_s4;
	p1tsa_pkg::tag_t      tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s1 <= hold_v_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			row_s1  <= ridx;
			col_s1  <= cidx;
			last_s1 <= lastk;
			pxx_s1  <= rnx * cnx;
			pyy_s1  <= rny * cny;
			pd1_s1  <= e1x_q * e2y_q;
			pd2_s1  <= e2x_q * e1y_q;

			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			dot_s2  <= {pxx_s1[PW-1], pxx_s1} + {pyy_s1[PW-1], pyy_s1};
			dd_s2   <= {pd1_s1[PW-1], pd1_s1} - {pd2_s1[PW-1], pd2_s1};

			row_s3   <= row_s2;
			col_s3   <= col_s2;
			last_s3  <= last_s2;
			neg_s3   <= dot_s2[SW-1];
			degen_s3 <= (dd_s2 == '0);
			mag_s3   <= dot_s2[SW-1] ? (~dot_s2 + SW'(1)) : dot_s2;
			den_s3   <= dd_s2[SW-1] ? (~dd_s2 + SW'(1)) : dd_s2;

			// (|dot| << F + |D|) / (2|D|) rounds half away from zero
			num_s4       <= (NW'(mag_s3) << COORD_FRAC_BITS) + NW'(den_s3);
			d2_s4        <= {den_s3, 1'b0};
			tag_s4.row   <= row_s3;
			tag_s4.col   <= col_s3;
			tag_s4.neg   <= neg_s3;
			tag_s4.degen <= degen_s3;
			tag_s4.last  <= last_s3;
		end
	end

	// ---------------- divider ----------------
	logic                 div_v, div_ovf;
	logic [QW-1:0]        div_q;
	p1tsa_pkg::tag_t      div_tag;

	p1tsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den2      (d2_s4),
		.in_tag    (tag_s4),
		.out_valid (div_v),
		.quot      (div_q),
		.ovf       (div_ovf),
		.out_tag   (div_tag)
	);

	// ---------------- saturate, sign, output register ----------------
	logic [CW-1:0] lim, mag_sat, val_c;
	assign lim     = div_tag.neg ? p1tsa_pkg::NEG_LIMIT : p1tsa_pkg::POS_LIMIT;
	assign mag_sat = (div_ovf || (div_q > lim)) ? lim : div_q;
	assign val_c   = div_tag.degen ? '0 : (div_tag.neg ? (~mag_sat + CW'(1)) : mag_sat);

	logic [IW-1:0] row_q, col_q;
	logic [CW-1:0] val_q;
	logic          degen_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (ce) begin
			ent_valid_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			row_q   <= div_tag.row;
			col_q   <= div_tag.col;
			val_q   <= val_c;
			degen_q <= div_tag.degen;
			last_q  <= div_tag.last;
		end
	end

	assign ent_valid   = ent_valid_q;
	assign row_node    = row_q;
	assign col_node    = col_q;
	assign entry_value = val_q;
	assign degenerate  = degen_q;
	assign last        = last_q;

	// ---------------- assertions ----------------
	a_seq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!hold_v_q |-> (r_q == 2'd0 && c_q == 2'd0))
		else $error("entry counter not at start while holding register empty");

	a_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!hold_v_q |-> !tri_stall)
		else $error("input stalled with holding register empty");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_valid && degenerate) |-> (entry_value == '0))
		else $error("degenerate triplet with nonzero value");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && lastk && !tri_valid) |=> !hold_v_q)
		else $error("holding register not released after ninth entry");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int IW = p1tsa_pkg::IDX_W;
	localparam int CW = p1tsa_pkg::CRD_W;

	// how the expected triplets of a triangle are obtained
	typedef enum logic [1:0] {EXP_CALC, EXP_UNIT, EXP_ZERO} exp_kind_t;

	typedef struct {
		logic [IW-1:0]        ia, ib, ic;
		logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
		exp_kind_t            kind;
	} triangle_t;

	typedef struct {
		logic [IW-1:0]        row, col;
		logic signed [CW-1:0] val;
		logic                 degen, lst;
	} triplet_t;

	localparam int  ONE       = 32'h0001_0000;
	localparam int  HALF      = 32'h0000_8000;
	localparam int  LIMIT_CYC = 400000;

	// Unit right triangle (0,0) (1,0) (0,1), column-major: entries read off directly.
	localparam int UNIT_K [9] = '{ONE, -HALF, -HALF, -HALF, HALF, 0, -HALF, 0, HALF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tri_valid = 1'b0;
	logic tri_stall;
	logic [IW-1:0] node_a_index = '0, node_b_index = '0, node_c_index = '0;
	logic signed [CW-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
	exp_kind_t cur_kind = EXP_CALC;
	logic ent_valid;
	logic ent_stall = 1'b0;
	logic [IW-1:0] row_node, col_node;
	logic signed [CW-1:0] entry_value;
	logic degenerate, last;

	always #1 clk = ~clk;

	p1_triangle_stiffness_assembly_top dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_stall(tri_stall),
		.node_a_index(node_a_index), .node_b_index(node_b_index),
		.node_c_index(node_c_index),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
		.ent_valid(ent_valid), .ent_stall(ent_stall),
		.row_node(row_node), .col_node(col_node), .entry_value(entry_value),
		.degenerate(degenerate), .last(last)
	);

	triplet_t  pending_triplets[$];
	triangle_t dir_tris[$];
	int        n_err = 0;
	int        cycles = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_cycles = 0;  // long receiver hold-off, counted down by the receiver
	bit        stim_done = 1'b0;

	// Exact P1 Laplacian: K[i][j] = (ni . nj) / (2|D|), rounded half away from zero,
	// saturated to 32 bits; EXP_UNIT uses UNIT_K, EXP_ZERO forces 0 and degenerate.
	function automatic void predict_triplets(triangle_t t);
		longint xs[3], ys[3], nx[3], ny[3];
		logic [IW-1:0] idx[3];
		logic signed [127:0] dd, den, dot, mag, q, lim;
		triplet_t e;
		int r, c;
		bit neg;
		idx = '{t.ia, t.ib, t.ic};
		xs = '{longint'(t.ax), longint'(t.bx), longint'(t.cx)};
		ys = '{longint'(t.ay), longint'(t.by), longint'(t.cy)};
		for (int i = 0; i < 3; i++) begin
			nx[i] = ys[(i+1)%3] - ys[(i+2)%3];
			ny[i] = xs[(i+2)%3] - xs[(i+1)%3];
		end
		dd = (xs[1]-xs[0]) * (ys[2]-ys[0]) - (xs[2]-xs[0]) * (ys[1]-ys[0]);
		den = dd < 0 ? -dd : dd;
		for (int k = 0; k < 9; k++) begin
			r = k % 3;
			c = k / 3;
			e.row = idx[r];
			e.col = idx[c];
			e.degen = (dd == 0);
			e.lst = (k == 8);
			if (dd == 0) begin
				e.val = 0;
			end else begin
				dot = nx[r] * nx[c] + ny[r] * ny[c];
				neg = dot < 0;
				mag = neg ? -dot : dot;
				q = ((mag <<< 16) + den) / (den * 2);
				lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
				if (q > lim)
					q = lim;
				e.val = neg ? -q[31:0] : q[31:0];
			end
			if (t.kind == EXP_UNIT)
				e.val = UNIT_K[k];
			else if (t.kind == EXP_ZERO) begin
				e.val = 0;
				e.degen = 1'b1;
			end
			pending_triplets.insert(pending_triplets.size(), e);
		end
	endfunction

	function automatic void queue_dir(triangle_t t);
		dir_tris.insert(dir_tris.size(), t);
	endfunction

	function automatic triangle_t tri_of(int a, int b, int c, int x0, int y0, int x1, int y1,
			int x2, int y2, exp_kind_t kind);
		triangle_t t;
		t.ia = IW'(a); t.ib = IW'(b); t.ic = IW'(c);
		t.ax = x0; t.ay = y0; t.bx = x1; t.by = y1; t.cx = x2; t.cy = y2;
		t.kind = kind;
		return t;
	endfunction

	// small coordinate, a few units either side of zero
	function automatic int small_crd();
		return $urandom_range(0, 8 * ONE) - 4 * ONE;
	endfunction

	function automatic triangle_t random_tri();
		triangle_t t;
		int mode, s;
		t.ia = IW'($urandom); t.ib = IW'($urandom); t.ic = IW'($urandom);
		t.kind = EXP_CALC;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// random triangle with small coordinates
			t.ax = small_crd(); t.ay = small_crd();
			t.bx = small_crd(); t.by = small_crd();
			t.cx = small_crd(); t.cy = small_crd();
		end else if (mode == 6) begin
			// collinear: c = a + s*(b-a)
			s = $urandom_range(0, 6) - 3;
			t.ax = small_crd(); t.ay = small_crd();
			t.bx = small_crd(); t.by = small_crd();
			t.cx = t.ax + s * (t.bx - t.ax);
			t.cy = t.ay + s * (t.by - t.ay);
		end else if (mode == 7) begin
			// sliver: tiny height, large entries
			t.ax = small_crd(); t.ay = small_crd();
			t.bx = t.ax + $urandom_range(1, 1 << 30);
			t.by = t.ay + $urandom_range(0, 3);
			t.cx = t.ax + $urandom_range(0, 1 << 30);
			t.cy = t.ay + $urandom_range(0, 7);
		end else begin
			t.ax = $urandom; t.ay = $urandom; t.bx = $urandom;
			t.by = $urandom; t.cx = $urandom; t.cy = $urandom;
		end
		return t;
	endfunction

	task automatic send_tri(triangle_t t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tri_valid = 1'b0;
			@(negedge clk);
		end
		node_a_index = t.ia; node_b_index = t.ib; node_c_index = t.ic;
		ax = t.ax; ay = t.ay; bx = t.bx; by_coord = t.by; cx = t.cx; cy = t.cy;
		cur_kind = t.kind;
		tri_valid = 1'b1;
		do @(posedge clk); while (!(tri_valid && !tri_stall));
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		int mx, mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		queue_dir(tri_of(0, 1, 2, 0, 0, ONE, 0, 0, ONE, EXP_UNIT));
		queue_dir(tri_of(16'hFFFF, 0, 16'hFFFF, 0, 0, ONE, 0, 0, ONE, EXP_UNIT));
		queue_dir(tri_of(5, 6, 7, 0, 0, 0, 0, 0, 0, EXP_ZERO));          // all same
		queue_dir(tri_of(1, 2, 3, 0, 0, ONE, ONE, 2*ONE, 2*ONE, EXP_ZERO)); // line
		queue_dir(tri_of(9, 9, 9, mx, mx, mx, mx, mx, mx, EXP_ZERO));
		queue_dir(tri_of(0, 1, 2, 0, 0, ONE, 0, ONE, ONE, EXP_CALC));     // ccw order
		queue_dir(tri_of(3, 4, 5, mn, mn, mx, mn, mn, mx, EXP_CALC));     // huge
		queue_dir(tri_of(3, 4, 5, mx, mx, mn, mx, mx, mn, EXP_CALC));
		queue_dir(tri_of(7, 8, 9, 0, 0, mx, 0, 0, 1, EXP_CALC));          // saturate
		queue_dir(tri_of(7, 8, 9, 0, 0, mx, 0, mx, 1, EXP_CALC));         // both signs
		queue_dir(tri_of(1, 2, 3, 0, 0, 1, 0, 0, 1, EXP_CALC));           // tiny
		queue_dir(tri_of(1, 2, 3, mn, 0, mx, 0, 0, mx, EXP_CALC));
		queue_dir(tri_of(16'hFFFF, 16'h8000, 16'h7FFF, -ONE, -ONE, ONE, -ONE,
			0, 3*ONE, EXP_CALC));
		queue_dir(tri_of(10, 11, 12, 0, 0, 3, 0, 1, 2, EXP_CALC));       // rounding
		queue_dir(tri_of(10, 11, 12, 0, 0, 3, 0, 2, 3, EXP_CALC));
		queue_dir(tri_of(20, 21, 22, mn, mn, mn, mx, mx, mn, EXP_CALC));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tris[i])
			send_tri(dir_tris[i]);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			if (ph == 0)
				hold_cycles = 300;   // sender keeps offering, pipeline backs up
			for (int n = 0; n < 84; n++) begin
				if (ph == 3 && n > 20 && n < 40) begin
					send_idle_pct = 0;   // a stretch with no idling
					stall_pct = 0;
				end else if (ph == 3) begin
					send_idle_pct = 25;
					stall_pct = 25;
				end
				send_tri(random_tri());
			end
		end
		tri_valid = 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stall
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			ent_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			ent_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Prediction on accepted triangles, check on accepted triplets
	always @(posedge clk) begin
		triangle_t t;
		triplet_t e;
		cycles <= cycles + 1;
		if (arst_n && tri_valid && !tri_stall) begin
			t.ia = node_a_index; t.ib = node_b_index; t.ic = node_c_index;
			t.ax = ax; t.ay = ay; t.bx = bx; t.by = by_coord; t.cx = cx; t.cy = cy;
			t.kind = cur_kind;
			predict_triplets(t);
		end
		if (arst_n && ent_valid && !ent_stall) begin
			if (pending_triplets.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word: row %0d col %0d val %h", row_node, col_node,
						entry_value);
			end else begin
				e = pending_triplets.pop_front();
				if (row_node !== e.row || col_node !== e.col || entry_value !== e.val ||
						degenerate !== e.degen || last !== e.lst) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp row %0d col %0d val %h dg %b l %b, got %0d %0d %h %b %b",
							e.row, e.col, e.val, e.degen, e.lst,
							row_node, col_node, entry_value, degenerate, last);
				end
			end
		end
	end

	// End of run
	initial begin
		wait (stim_done);
		while (pending_triplets.size() != 0 && cycles < LIMIT_CYC)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (pending_triplets.size() == 0 && n_err == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		wait (cycles >= LIMIT_CYC);
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
